/* design/assert_macros.svh */
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet during reset
`define SSFU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define SSFU_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ssfu_pkg.sv */
`timescale 1ns / 1ps
package ssfu_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_MAX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_SPACING = 2'd1;
    localparam logic [15:0] RATE_MAX_RESET = 16'd4096;
    localparam logic [15:0] SEED_SPACING_RESET = 16'd41;

    localparam int TEMP_W = 24;
    localparam int CORR_W = 32;
    localparam int FILL_W = 17;
    localparam int RATE_W = 16;
    localparam int BEST_W = 4;
    localparam int QUOT_BITS = 16;
    localparam int TEMP_MAX = 8388607;
    localparam int TEMP_MIN = -8388608;
    localparam logic [FILL_W-1:0] FILL_ONE = 17'd65536;

    typedef struct packed {
        logic load;
        logic seed;
        logic scan;
        logic square;
        logic div_load;
        logic div_step;
        logic upd;
        logic emit;
    } ssfu_cmd_t;

    typedef struct packed {
        logic seeded;
        logic cnt_last;
        logic scan_done;
        logic div_done;
        logic upd_done;
        logic out_busy;
    } ssfu_sts_t;

    // exp(-2 d^2) in Q1.16
    function automatic logic [FILL_W-1:0] nb_weight(input logic [5:0] d);
        logic [FILL_W-1:0] w;
        case (d)
            6'd0:    w = 17'd65536;
            6'd1:    w = 17'd8869;
            6'd2:    w = 17'd22;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

/* design/ssfu_ram.sv */
`timescale 1ns / 1ps
module ssfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/ssfu_datapath.sv */
`timescale 1ns / 1ps
module ssfu_datapath #(
    parameter int NODES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ssfu_pkg::ssfu_cmd_t                 cmd,
    output ssfu_pkg::ssfu_sts_t                 sts,
    input  logic                                cfg_we,
    input  logic [ssfu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssfu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [ssfu_pkg::TEMP_W-1:0]  temperature,
    input  logic signed [ssfu_pkg::CORR_W-1:0]  correction,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [ssfu_pkg::BEST_W-1:0]         best_node,
    output logic [ssfu_pkg::RATE_W-1:0]         learn_rate,
    output logic                                seeded_now
);

    localparam int AW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int FSUM_W = ssfu_pkg::FILL_W + $clog2(NODES);
    localparam int DEN_W = 2 * FSUM_W + 1;
    localparam int DSH_W = DEN_W + ssfu_pkg::QUOT_BITS - 1;
    localparam int QCW = $clog2(ssfu_pkg::QUOT_BITS);
    localparam int TW = ssfu_pkg::TEMP_W;
    localparam int KW = ssfu_pkg::CORR_W;
    localparam int FW = ssfu_pkg::FILL_W;
    localparam int SW = TW + 2;

    logic [15:0] rate_max_reg, seed_spacing_reg;
    logic        map_seeded_reg;
    logic        seeded_now_reg;
    logic signed [TW-1:0] t_reg;
    logic signed [KW-1:0] c_reg;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [TW-1:0] rd_temp;
    logic [KW-1:0] rd_corr;
    logic [FW-1:0] rd_fill;
    logic          we;
    logic [AW-1:0] waddr;
    logic [TW-1:0] wd_temp;
    logic [KW-1:0] wd_corr;
    logic [FW-1:0] wd_fill;
    logic          issue;

    logic          sa_v_reg;
    logic [AW-1:0] sa_idx_reg;
    logic [AW-1:0] best_reg;
    logic [TW:0]   bdist_reg;
    logic [FSUM_W-1:0] fsum_reg;
    logic [2*FSUM_W-1:0] sq_reg;

    logic [DSH_W-1:0] rem_reg, dsh_reg;
    logic [QCW-1:0]   qcnt_reg;
    logic [ssfu_pkg::RATE_W-1:0] q_reg;

    logic          ua_v_reg, ub_v_reg, uc_v_reg;
    logic [AW-1:0] ua_idx_reg, ub_idx_reg, uc_idx_reg;
    logic [15:0]   w_reg;
    logic signed [TW-1:0] tb_reg, tc_reg;
    logic signed [KW-1:0] cb_reg, cc_reg;
    logic [FW-1:0] fb_reg, fc_reg;
    logic signed [41:0] pt_reg;
    logic signed [49:0] pc_reg;
    logic signed [34:0] pf_reg;

    logic          out_valid_reg;
    logic [ssfu_pkg::BEST_W-1:0] best_out_reg;
    logic [ssfu_pkg::RATE_W-1:0] rate_out_reg;
    logic          seeded_out_reg;

    // seeding
    logic signed [CW:0]   seed_off;
    logic signed [CW+17:0] seed_prod;
    logic signed [SW-1:0] seed_sum;
    logic signed [TW-1:0] seed_temp;

    assign seed_off = $signed({1'b0, cnt_reg}) - $signed((CW + 1)'(NODES / 2));
    assign seed_prod = $signed({2'b00, seed_spacing_reg}) * seed_off;
    assign seed_sum = SW'(t_reg) + SW'(seed_prod);

    always_comb
    begin
        if (seed_sum > $signed(SW'(ssfu_pkg::TEMP_MAX)))
        begin
            seed_temp = TW'(ssfu_pkg::TEMP_MAX);
        end
        else if (seed_sum < $signed(SW'(ssfu_pkg::TEMP_MIN)))
        begin
            seed_temp = TW'(ssfu_pkg::TEMP_MIN);
        end
        else
        begin
            seed_temp = seed_sum[TW-1:0];
        end
    end

    // node memories
    assign issue = (cmd.scan || cmd.upd) && (cnt_reg < CW'(NODES));

    always_comb
    begin
        if (cmd.seed)
        begin
            cnt_next = sts.cnt_last ? '0 : cnt_reg + 1'b1;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.scan || cmd.upd)
        begin
            cnt_next = cnt_reg;
        end
        else
        begin
            cnt_next = '0;
        end
    end

    logic signed [TW-1:0] new_t;
    logic signed [KW-1:0] new_c;
    logic [FW-1:0]        new_f;
    logic signed [41:0]   rt;
    logic signed [49:0]   rc;
    logic signed [34:0]   rf;

    assign rt = (pt_reg + 42'sd32768) >>> 16;
    assign rc = (pc_reg + 50'sd32768) >>> 16;
    assign rf = (pf_reg + 35'sd32768) >>> 16;
    assign new_t = tc_reg + rt[TW-1:0];
    assign new_c = cc_reg + rc[KW-1:0];
    assign new_f = fc_reg + rf[FW-1:0];

    assign we = cmd.seed || uc_v_reg;
    assign waddr = cmd.seed ? cnt_reg[AW-1:0] : uc_idx_reg;
    assign wd_temp = cmd.seed ? seed_temp : new_t;
    assign wd_corr = cmd.seed ? c_reg : new_c;
    assign wd_fill = cmd.seed ? '0 : new_f;

    ssfu_ram #(.WIDTH(TW), .DEPTH(NODES)) u_temp_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wd_temp),
        .raddr(cnt_reg[AW-1:0]), .rdata(rd_temp)
    );

    ssfu_ram #(.WIDTH(KW), .DEPTH(NODES)) u_corr_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wd_corr),
        .raddr(cnt_reg[AW-1:0]), .rdata(rd_corr)
    );

    ssfu_ram #(.WIDTH(FW), .DEPTH(NODES)) u_fill_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wd_fill),
        .raddr(cnt_reg[AW-1:0]), .rdata(rd_fill)
    );

    // nearest node search
    logic signed [TW:0] sdiff;
    logic [TW:0]        sdist;

    assign sdiff = (TW + 1)'(t_reg) - (TW + 1)'($signed(rd_temp));
    assign sdist = sdiff[TW] ? (TW + 1)'(-sdiff) : (TW + 1)'(sdiff);

    // divider
    logic [DEN_W-1:0] den;
    logic             ge;

    assign den = DEN_W'(sq_reg) + (DEN_W'(1) << 32);
    assign ge = rem_reg >= dsh_reg;

    // neighbour weight
    logic [AW-1:0] nd;
    logic [32:0]   wprod;

    assign nd = (ua_idx_reg >= best_reg) ? ua_idx_reg - best_reg : best_reg - ua_idx_reg;
    assign wprod = q_reg * ssfu_pkg::nb_weight(6'(nd));

    logic signed [TW:0]   dt;
    logic signed [KW:0]   dc;
    logic signed [FW:0]   df;
    logic signed [16:0]   ws;

    assign ws = $signed({1'b0, w_reg});
    assign dt = (TW + 1)'(t_reg) - (TW + 1)'(tb_reg);
    assign dc = (KW + 1)'(c_reg) - (KW + 1)'(cb_reg);
    assign df = $signed({1'b0, ssfu_pkg::FILL_ONE}) - $signed({1'b0, fb_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_max_reg <= ssfu_pkg::RATE_MAX_RESET;
            seed_spacing_reg <= ssfu_pkg::SEED_SPACING_RESET;
            map_seeded_reg <= 1'b0;
            cnt_reg <= '0;
            sa_v_reg <= 1'b0;
            ua_v_reg <= 1'b0;
            ub_v_reg <= 1'b0;
            uc_v_reg <= 1'b0;
            qcnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ssfu_pkg::REG_RATE_MAX:     rate_max_reg <= cfg_data;
                    ssfu_pkg::REG_SEED_SPACING: seed_spacing_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.seed && sts.cnt_last)
            begin
                map_seeded_reg <= 1'b1;
            end
            cnt_reg <= cnt_next;
            sa_v_reg <= issue && cmd.scan;
            ua_v_reg <= issue && cmd.upd;
            ub_v_reg <= ua_v_reg;
            uc_v_reg <= ub_v_reg;
            if (cmd.div_load)
            begin
                qcnt_reg <= QCW'(ssfu_pkg::QUOT_BITS - 1);
            end
            else if (cmd.div_step)
            begin
                qcnt_reg <= qcnt_reg - 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg <= temperature;
            c_reg <= correction;
            seeded_now_reg <= 1'b0;
            fsum_reg <= '0;
        end
        if (cmd.seed)
        begin
            seeded_now_reg <= 1'b1;
        end
        sa_idx_reg <= cnt_reg[AW-1:0];
        if (sa_v_reg)
        begin
            if (sa_idx_reg == '0)
            begin
                best_reg <= '0;
                bdist_reg <= sdist;
            end
            else
            begin
                fsum_reg <= fsum_reg + FSUM_W'(rd_fill);
                if (sdist < bdist_reg)
                begin
                    best_reg <= sa_idx_reg;
                    bdist_reg <= sdist;
                end
            end
        end
        if (cmd.square)
        begin
            sq_reg <= fsum_reg * fsum_reg;
        end
        if (cmd.div_load)
        begin
            rem_reg <= DSH_W'({rate_max_reg, 32'd0});
            dsh_reg <= DSH_W'(den) << (ssfu_pkg::QUOT_BITS - 1);
        end
        else if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg <= {q_reg[ssfu_pkg::RATE_W-2:0], ge};
        end
        ua_idx_reg <= cnt_reg[AW-1:0];
        ub_idx_reg <= ua_idx_reg;
        uc_idx_reg <= ub_idx_reg;
        w_reg <= wprod[31:16];
        tb_reg <= $signed(rd_temp);
        cb_reg <= $signed(rd_corr);
        fb_reg <= rd_fill;
        tc_reg <= tb_reg;
        cc_reg <= cb_reg;
        fc_reg <= fb_reg;
        pt_reg <= 42'(dt * ws);
        pc_reg <= 50'(dc * ws);
        pf_reg <= 35'(df * ws);
        if (cmd.emit)
        begin
            best_out_reg <= ssfu_pkg::BEST_W'(best_reg);
            rate_out_reg <= q_reg;
            seeded_out_reg <= seeded_now_reg;
        end
    end

    always_comb
    begin
        sts.seeded = map_seeded_reg;
        sts.cnt_last = cnt_reg == CW'(NODES - 1);
        sts.scan_done = sa_v_reg && (sa_idx_reg == AW'(NODES - 1));
        sts.div_done = qcnt_reg == '0;
        sts.upd_done = uc_v_reg && (uc_idx_reg == AW'(NODES - 1));
        sts.out_busy = out_valid_reg && out_stall;
    end

    assign out_valid = out_valid_reg;
    assign best_node = best_out_reg;
    assign learn_rate = rate_out_reg;
    assign seeded_now = seeded_out_reg;

endmodule

/* design/ssfu_ctrl.sv */
`timescale 1ns / 1ps
module ssfu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output ssfu_pkg::ssfu_cmd_t cmd,
    input  ssfu_pkg::ssfu_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_SCAN,
        ST_SQUARE,
        ST_DIV_LOAD,
        ST_DIV,
        ST_UPDATE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = sts.seeded ? ST_SCAN : ST_SEED;
                end
            end
            ST_SEED:
            begin
                cmd.seed = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.upd = 1'b1;
                if (sts.upd_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/som_sample_filter_update_unit.sv */
`timescale 1ns / 1ps
// One-dimensional self-organising map update: each sample transaction finds the
// node nearest in temperature, derives the learning rate from the node fills and
// pulls the nearest node and its neighbours within two places toward the sample;
// the first sample after reset seeds the map, which adds a walk over the nodes.
// Each sample walks the node memories twice (one node read per cycle) and runs
// the 16-step restoring divider for the rate. One sample is in work at a time;
// a finished result waits in the output register while the next sample is
// taken. No clearing pass after reset.
module som_sample_filter_update_unit #(
    parameter int NODES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ssfu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssfu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [ssfu_pkg::TEMP_W-1:0]  temperature,
    input  logic signed [ssfu_pkg::CORR_W-1:0]  correction,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ssfu_pkg::BEST_W-1:0]         best_node,
    output logic [ssfu_pkg::RATE_W-1:0]         learn_rate,
    output logic                                seeded_now
);

    ssfu_pkg::ssfu_cmd_t cmd;
    ssfu_pkg::ssfu_sts_t sts;

    ssfu_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .sts(sts)
    );

    ssfu_datapath #(.NODES(NODES)) u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .sts(sts),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .temperature(temperature),
        .correction(correction),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .best_node(best_node),
        .learn_rate(learn_rate),
        .seeded_now(seeded_now)
    );

endmodule

/* design/ssfu_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssfu_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [ssfu_pkg::BEST_W-1:0]  best_node,
    input logic [ssfu_pkg::RATE_W-1:0]  learn_rate,
    input logic                         seeded_now
);

    `SSFU_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(best_node) && $stable(learn_rate) && $stable(seeded_now), "stalled result changed")
    `SSFU_ASSERT(a_one_in_work, clk, rst_n, in_valid && !in_stall |=> in_stall, "second transaction taken while busy")
    `SSFU_ASSERT(a_no_early_result, clk, rst_n, in_valid && !in_stall |=> !$rose(out_valid), "result appeared straight after acceptance")
    `SSFU_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> !out_valid, "result valid during reset")

endmodule

bind som_sample_filter_update_unit ssfu_checker u_ssfu_checker (.*);

/* test/som_sample_filter_update_checker.sv */
`timescale 1ns / 1ps
module som_sample_filter_update_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ssfu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssfu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [ssfu_pkg::TEMP_W-1:0]  temperature,
    input  logic signed [ssfu_pkg::CORR_W-1:0]  correction,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [ssfu_pkg::BEST_W-1:0]         best_node,
    input  logic [ssfu_pkg::RATE_W-1:0]         learn_rate,
    input  logic                                seeded_now,
    output int                                  pending,
    output int                                  errors
);

    localparam int MAP_NODES = 16;

    typedef struct packed {
        logic [ssfu_pkg::BEST_W-1:0] best;
        logic [ssfu_pkg::RATE_W-1:0] rate;
        logic                        seeded;
    } update_result_t;

    update_result_t result_q[$];

    logic [15:0] rate_max_q;
    logic [15:0] spacing_q;
    longint      map_temp[MAP_NODES];
    longint      map_corr[MAP_NODES];
    longint      map_fill[MAP_NODES];
    logic        map_ready;

    function automatic longint round_q16(input longint p);
        longint q;
        q = p + 32768;
        if (q >= 0)
            return q >>> 16;
        return -((-q + 65535) >>> 16);
    endfunction

    function automatic longint nb_table(input int d);
        case (d)
            0:       return 65536;
            1:       return 8869;
            2:       return 22;
            default: return 0;
        endcase
    endfunction

    function automatic update_result_t apply_sample(input longint t, input longint c);
        update_result_t r;
        longint v;
        longint best_dist;
        longint d;
        longint w;
        longint unsigned fsum;
        longint unsigned rate;
        int best;
        int nd;
        r.seeded = 1'b0;
        if (!map_ready)
        begin
            for (int i = 0; i < MAP_NODES; i++)
            begin
                v = t + longint'(spacing_q) * (i - MAP_NODES / 2);
                if (v > ssfu_pkg::TEMP_MAX) v = ssfu_pkg::TEMP_MAX;
                if (v < ssfu_pkg::TEMP_MIN) v = ssfu_pkg::TEMP_MIN;
                map_temp[i] = v;
                map_corr[i] = c;
                map_fill[i] = 0;
            end
            map_ready = 1'b1;
            r.seeded = 1'b1;
        end
        best = 0;
        fsum = 0;
        best_dist = t - map_temp[0];
        if (best_dist < 0) best_dist = -best_dist;
        for (int i = 1; i < MAP_NODES; i++)
        begin
            d = t - map_temp[i];
            if (d < 0) d = -d;
            fsum += longint'(map_fill[i]);
            if (d < best_dist)
            begin
                best_dist = d;
                best = i;
            end
        end
        rate = (longint'(rate_max_q) << 32) / ((64'd1 << 32) + fsum * fsum);
        for (int i = 0; i < MAP_NODES; i++)
        begin
            nd = (i > best) ? i - best : best - i;
            w = longint'((rate * nb_table(nd)) >> 16);
            map_temp[i] = map_temp[i] + round_q16((t - map_temp[i]) * w);
            map_corr[i] = map_corr[i] + round_q16((c - map_corr[i]) * w);
            map_fill[i] = map_fill[i] + round_q16((65536 - map_fill[i]) * w);
        end
        r.best = best[ssfu_pkg::BEST_W-1:0];
        r.rate = rate[ssfu_pkg::RATE_W-1:0];
        return r;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        update_result_t want;
        if (!rst_n)
        begin
            rate_max_q = ssfu_pkg::RATE_MAX_RESET;
            spacing_q = ssfu_pkg::SEED_SPACING_RESET;
            map_ready = 1'b0;
            result_q.delete();
            pending = 0;
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == ssfu_pkg::REG_RATE_MAX)
                    rate_max_q = cfg_data;
                else if (cfg_index == ssfu_pkg::REG_SEED_SPACING)
                    spacing_q = cfg_data;
            end
            if (in_valid && !in_stall)
                result_q.push_back(apply_sample(longint'(temperature), longint'(correction)));
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    report("unexpected result transaction", 1, 0);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (best_node !== want.best)
                        report("best_node", best_node, want.best);
                    if (learn_rate !== want.rate)
                        report("learn_rate", learn_rate, want.rate);
                    if (seeded_now !== want.seeded)
                        report("seeded_now", seeded_now, want.seeded);
                end
            end
            pending = result_q.size();
        end
    end

endmodule

/* test/tb_som_sample_filter_update_unit.sv */
`timescale 1ns / 1ps
module tb_som_sample_filter_update_unit;

    localparam int SPACING = 65534;
    localparam int BASE = ssfu_pkg::TEMP_MAX - 3 * SPACING;
    localparam int LIMIT = 3000000;
    localparam int TW = ssfu_pkg::TEMP_W;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [ssfu_pkg::CFG_IDX_W-1:0]      cfg_index = ssfu_pkg::REG_RATE_MAX;
    logic [ssfu_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic signed [ssfu_pkg::TEMP_W-1:0]  temperature = '0;
    logic signed [ssfu_pkg::CORR_W-1:0]  correction = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [ssfu_pkg::BEST_W-1:0]         best_node;
    logic [ssfu_pkg::RATE_W-1:0]         learn_rate;
    logic                                seeded_now;
    int                                  pending;
    int                                  errors;
    int                                  snd_idle_pct = 0;
    int                                  rcv_idle_pct = 0;
    int                                  hold_req = 0;
    int                                  cycles = 0;

    always #1 clk = ~clk;

    som_sample_filter_update_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .temperature (temperature),
        .correction  (correction),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .best_node   (best_node),
        .learn_rate  (learn_rate),
        .seeded_now  (seeded_now)
    );

    som_sample_filter_update_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .temperature (temperature),
        .correction  (correction),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .best_node   (best_node),
        .learn_rate  (learn_rate),
        .seeded_now  (seeded_now),
        .pending     (pending),
        .errors      (errors)
    );

    // receiver, with long hold-off on request
    always @(negedge clk)
    begin
        int hold_seen;
        int hold_left;
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAIL som_sample_filter_update_unit");
            $finish;
        end
    end

    task automatic send(input logic signed [ssfu_pkg::TEMP_W-1:0] t,
                        input logic signed [ssfu_pkg::CORR_W-1:0] c);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        temperature <= t;
        correction <= c;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (90) @(negedge clk);
    endtask

    task automatic write_reg(input logic [ssfu_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        logic signed [ssfu_pkg::TEMP_W-1:0] t;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(3))
                0:       t = TW'($urandom);
                1:       t = TW'(BASE + $signed($urandom_range(40 * SPACING)) - 30 * SPACING);
                default: t = TW'(BASE + $signed($urandom_range(2000)) - 1000 - 8 * SPACING
                                 + $signed($urandom_range(10)) * SPACING);
            endcase
            send(t, $urandom);
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // static map for nearest-node checks: no learning while rate_max is zero
        write_reg(ssfu_pkg::REG_RATE_MAX, 16'd0);
        write_reg(ssfu_pkg::REG_SEED_SPACING, SPACING[15:0]);
        write_reg(2'd2, 16'hffff);
        write_reg(2'd3, 16'h5555);
        send(TW'(BASE), 32'sh8000_0000);
        for (int k = 0; k < 11; k++)
            send(TW'(BASE + SPACING * (k - 8) + SPACING / 2 - 1), 32'sh7fff_ffff);
        send(TW'(ssfu_pkg::TEMP_MAX), 32'sh7fff_ffff);
        send(TW'(ssfu_pkg::TEMP_MIN), 32'sh8000_0000);
        send(TW'(BASE + 3 * SPACING - 1), 32'sd0);
        settle();
        write_reg(ssfu_pkg::REG_RATE_MAX, 16'hffff);
        write_reg(ssfu_pkg::REG_SEED_SPACING, 16'hffff);
        send(TW'(ssfu_pkg::TEMP_MAX), 32'sh7fff_ffff);
        send(TW'(ssfu_pkg::TEMP_MIN), 32'sh8000_0000);
        send(24'sd0, 32'sd0);
        send(24'sh555555, 32'sh5555_5555);
        send(24'shaaaaaa, 32'shaaaa_aaaa);
        settle();
        write_reg(ssfu_pkg::REG_RATE_MAX, 16'd1);
        send(TW'(BASE), 32'sd1);
        send(TW'(BASE - 1), -32'sd1);
        settle();

        snd_idle_pct = 19;
        rcv_idle_pct = 75;
        write_reg(ssfu_pkg::REG_RATE_MAX, ssfu_pkg::RATE_MAX_RESET);
        write_reg(ssfu_pkg::REG_SEED_SPACING, 16'd0);
        random_phase(150);
        hold_req = hold_req + 1;
        random_phase(150);
        settle();

        snd_idle_pct = 75;
        rcv_idle_pct = 19;
        write_reg(ssfu_pkg::REG_RATE_MAX, 16'($urandom));
        write_reg(ssfu_pkg::REG_SEED_SPACING, 16'($urandom));
        random_phase(300);
        settle();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_reg(ssfu_pkg::REG_RATE_MAX, 16'hffff);
        random_phase(150);
        settle();
        write_reg(ssfu_pkg::REG_RATE_MAX, 16'($urandom_range(4096)));
        random_phase(150);
        settle();

        if (errors == 0)
            $display("PASS som_sample_filter_update_unit");
        else
            $display("FAIL som_sample_filter_update_unit");
        $finish;
    end

endmodule
